>>> hw/rtl/slrg_pkg.sv
// Shared types and constants for the subtractive lagged random generator.
`default_nettype none

package slrg_pkg;

    localparam int FRAC_BITS_DEF = 32;
    localparam int BOUND_BITS    = 24;
    localparam int SEED_BITS     = 32;
    localparam int OUT_FRAC_BITS = 32;
    localparam int REAL_BITS     = 56;
    localparam int TABLE_LEN     = 55;
    localparam int IDX_W         = 6;
    localparam int MUL_CHUNK     = 26;

    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_LEN - 1);
    localparam logic [IDX_W-1:0] LAG_SHORT  = IDX_W'(24);
    localparam logic [IDX_W-1:0] LAG_OFFSET = IDX_W'(31);
    localparam logic [IDX_W-1:0] WARM_STEP  = IDX_W'(21);
    localparam logic [IDX_W:0]   WARM_MOD   = (IDX_W + 1)'(54);

    localparam logic CMD_RESEED = 1'b0;
    localparam logic CMD_DRAW   = 1'b1;

    typedef struct packed {
        logic                         cmd;
        logic signed [BOUND_BITS-1:0] low_bound;
        logic signed [BOUND_BITS-1:0] high_bound;
    } item_t;

    typedef struct packed {
        logic [OUT_FRAC_BITS-1:0]     fraction;
        logic signed [BOUND_BITS-1:0] int_value;
        logic signed [REAL_BITS-1:0]  real_value;
    } result_t;

    typedef struct packed {
        logic             clear;
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] raddr_a;
        logic [IDX_W-1:0] raddr_b;
    } tbl_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/slrg_table.sv
// Fraction table memory with two registered read ports and per-entry valid bits.
`default_nettype none

module slrg_table #(
    parameter int FRAC_BITS = slrg_pkg::FRAC_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire slrg_pkg::tbl_ctl_t   ctl,
    input  wire logic [FRAC_BITS-1:0] wdata,
    output logic      [FRAC_BITS-1:0] rdata_a,
    output logic      [FRAC_BITS-1:0] rdata_b
);
    import slrg_pkg::*;

    logic [FRAC_BITS-1:0] mem [TABLE_LEN];
    logic [TABLE_LEN-1:0] valid_reg;
    logic [TABLE_LEN-1:0] valid_next;
    logic [FRAC_BITS-1:0] rd_a_reg;
    logic [FRAC_BITS-1:0] rd_b_reg;

    // An entry that has not been written since the last clear reads as zero.
    always_comb
    begin
        valid_next = ctl.clear ? '0 : valid_reg;
        if (ctl.we)
        begin
            valid_next[ctl.waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= wdata;
        end
        rd_a_reg <= valid_reg[ctl.raddr_a] ? mem[ctl.raddr_a] : '0;
        rd_b_reg <= valid_reg[ctl.raddr_b] ? mem[ctl.raddr_b] : '0;
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

`default_nettype wire

>>> hw/rtl/slrg_scale.sv
// Range scaling unit: iterative chunked multiply and formation of the result fields.
`default_nettype none

module slrg_scale #(
    parameter int FRAC_BITS = slrg_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic [FRAC_BITS-1:0]                   frac,
    input  wire logic signed [slrg_pkg::BOUND_BITS-1:0] low_bound,
    input  wire logic signed [slrg_pkg::BOUND_BITS-1:0] high_bound,
    output logic                                        done,
    output slrg_pkg::result_t                           res
);
    import slrg_pkg::*;

    localparam int NCH    = (FRAC_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int PAD_W  = NCH * MUL_CHUNK;
    localparam int MAG_W  = BOUND_BITS;
    localparam int ACC_W  = MAG_W + PAD_W;
    localparam int PROD_W = MAG_W + MUL_CHUNK;
    localparam int CNT_W  = $clog2(NCH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [FRAC_BITS-1:0]          frac_reg;
    logic [PAD_W-1:0]              sh_reg;
    logic [MAG_W-1:0]              mag_reg;
    logic                          neg_reg;
    logic                          le_reg;
    logic signed [BOUND_BITS-1:0]  lo_reg;
    logic signed [BOUND_BITS-1:0]  hi_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic [ACC_W-1:0]              acc_reg;
    logic [MAG_W:0]                q_reg;
    logic [REAL_BITS-1:0]          aln_reg;
    logic [OUT_FRAC_BITS-1:0]      fout_reg;
    result_t                       res_reg;

    logic signed [BOUND_BITS:0]    diff;
    logic [BOUND_BITS:0]           diff_abs;
    logic [MUL_CHUNK-1:0]          chunk;
    logic [ACC_W:0]                sum;
    logic [ACC_W+31:0]             aln_wide;
    logic [FRAC_BITS+31:0]         frac_wide;
    logic signed [BOUND_BITS:0]    lo_ext;
    logic signed [BOUND_BITS:0]    hi_ext;
    logic signed [BOUND_BITS:0]    ival;
    logic [REAL_BITS-1:0]          base;
    result_t                       res_next;

    assign diff     = {high_bound[BOUND_BITS-1], high_bound}
                    - {low_bound[BOUND_BITS-1], low_bound};
    assign diff_abs = diff[BOUND_BITS] ? (BOUND_BITS + 1)'(-diff) : diff;
    assign chunk    = sh_reg[PAD_W-1 -: MUL_CHUNK];
    assign sum      = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(frac_reg);
    assign aln_wide = {acc_reg, 32'b0} >> FRAC_BITS;
    assign frac_wide = {frac_reg, 32'b0} >> FRAC_BITS;
    assign lo_ext   = {lo_reg[BOUND_BITS-1], lo_reg};
    assign hi_ext   = {hi_reg[BOUND_BITS-1], hi_reg};
    assign base     = {lo_reg, 32'b0};

    always_comb
    begin
        ival = lo_ext + $signed(q_reg);
        if (le_reg)
        begin
            ival = lo_ext;
        end
        else if (ival > hi_ext)
        begin
            ival = hi_ext;
        end
        res_next.fraction   = fout_reg;
        res_next.int_value  = ival[BOUND_BITS-1:0];
        res_next.real_value = neg_reg ? $signed(base - aln_reg) : $signed(base + aln_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MUL;
                    cnt_next   = CNT_W'(NCH - 1);
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_SUM;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = ST_MUL;
                end
            end
            ST_SUM:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            frac_reg <= frac;
            sh_reg   <= PAD_W'(frac);
            mag_reg  <= diff_abs[MAG_W-1:0];
            neg_reg  <= diff[BOUND_BITS];
            le_reg   <= (low_bound >= high_bound);
            lo_reg   <= low_bound;
            hi_reg   <= high_bound;
            acc_reg  <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(chunk);
            sh_reg   <= sh_reg << MUL_CHUNK;
        end
        if (state_reg == ST_ACC)
        begin
            acc_reg <= (acc_reg << MUL_CHUNK) + ACC_W'(prod_reg);
        end
        if (state_reg == ST_SUM)
        begin
            q_reg    <= sum[FRAC_BITS +: MAG_W + 1];
            aln_reg  <= aln_wide[REAL_BITS-1:0];
            fout_reg <= frac_wide[OUT_FRAC_BITS-1:0];
        end
        if (state_reg == ST_FIN)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= (state_reg == ST_FIN);
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

>>> hw/rtl/subtractive_lagged_random_generator_core.sv
// Top level of the subtractive lagged random generator: sequencer, register port, table.
// A draw reads its fraction from the table, runs the chunked multiply in the scaling unit and
// then enters the output state; a draw that wraps the read index first runs a refresh pass.
// A reseed runs 54 warm-up writes, three refresh passes and the output state in turn. The
// next item can be taken in the cycle after the result is loaded.
// Reset is asynchronous, active low: the table reads as zero, read index zero, seed one half.
`default_nettype none

module subtractive_lagged_random_generator_core #(
    parameter int FRAC_BITS = slrg_pkg::FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire slrg_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output slrg_pkg::result_t      result
);
    import slrg_pkg::*;

    // Round(1e-9 * 2^FRAC_BITS) starts the warm-up sequence.
    localparam logic [FRAC_BITS-1:0] WARM_START =
        FRAC_BITS'(((64'd1 << FRAC_BITS) + 64'd500000000) / 64'd1000000000);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_WARM    = 4'd1;
    localparam logic [3:0] S_REF_RD  = 4'd2;
    localparam logic [3:0] S_REF_WR  = 4'd3;
    localparam logic [3:0] S_DRAW_RD = 4'd4;
    localparam logic [3:0] S_DRAW_LD = 4'd5;
    localparam logic [3:0] S_MUL     = 4'd6;
    localparam logic [3:0] S_OUT     = 4'd7;

    // Control state.
    logic [3:0]            state_reg, state_next;
    logic [IDX_W-1:0]      step_reg, step_next;     // warm-up step counter j
    logic [IDX_W-1:0]      ridx_reg, ridx_next;     // refresh pass entry
    logic [1:0]            pass_reg, pass_next;
    logic [IDX_W-1:0]      rd_index_reg, rd_index_next;
    logic                  draw_reg, draw_next;     // refresh belongs to a draw
    logic                  result_valid_reg, result_valid_next;
    logic [SEED_BITS-1:0]  seed_reg, seed_next;

    // Working values.
    logic [FRAC_BITS-1:0]         prev_reg, cur_reg;
    logic [IDX_W-1:0]             pos_reg;
    logic signed [BOUND_BITS-1:0] lo_reg, hi_reg;
    result_t                      result_reg;

    logic                  accept;
    logic                  cfg_write;
    tbl_ctl_t              tbl_ctl;
    logic [FRAC_BITS-1:0]  tbl_wdata;
    logic [FRAC_BITS-1:0]  rdata_a, rdata_b;
    logic [FRAC_BITS-1:0]  sub_a, sub_b, sub_res;
    logic [FRAC_BITS+31:0] seed_wide;
    logic [FRAC_BITS-1:0]  seed_scaled;
    logic [IDX_W:0]        pos_sum;
    logic [IDX_W-1:0]      pos_wrap;
    logic [IDX_W-1:0]      partner;
    logic                  scale_start;
    logic                  scale_done;
    result_t               scale_res;

    // Configuration port. Only the seed register exists; it sits at byte address zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && !paddr[2];
    assign prdata    = paddr[2] ? 32'b0 : seed_reg;
    assign seed_next = cfg_write ? pwdata : seed_reg;

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The seed is a Q0.32 fraction; bring it to the table's fraction width by truncation.
    assign seed_wide   = {seed_reg, FRAC_BITS'(0)} >> SEED_BITS;
    assign seed_scaled = seed_wide[FRAC_BITS-1:0];

    // The one table subtractor, modulo 1, shared by warm-up and refresh.
    assign sub_a   = (state_reg == S_WARM) ? prev_reg : rdata_a;
    assign sub_b   = (state_reg == S_WARM) ? cur_reg  : rdata_b;
    assign sub_res = sub_a - sub_b;

    // Warm-up scatter: the next position is (pos + 21) mod 54.
    assign pos_sum  = {1'b0, pos_reg} + {1'b0, WARM_STEP};
    assign pos_wrap = (pos_sum >= WARM_MOD) ? IDX_W'(pos_sum - WARM_MOD) : pos_sum[IDX_W-1:0];

    // Refresh partner: the lower 24 entries pair with the entry 31 above, the rest with
    // the entry 24 below, which the same pass has already renewed.
    assign partner = (ridx_reg < LAG_SHORT) ? ridx_reg + LAG_OFFSET : ridx_reg - LAG_SHORT;

    assign scale_start = (state_reg == S_DRAW_LD);

    always_comb
    begin
        tbl_ctl.clear   = 1'b0;
        tbl_ctl.we      = 1'b0;
        tbl_ctl.waddr   = ridx_reg;
        tbl_ctl.raddr_a = ridx_reg;
        tbl_ctl.raddr_b = partner;
        tbl_wdata       = sub_res;
        unique case (state_reg)
            S_IDLE:
            begin
                // A reseed clears the whole table and plants the seed in the last entry.
                if (accept && item.cmd == CMD_RESEED)
                begin
                    tbl_ctl.clear = 1'b1;
                    tbl_ctl.we    = 1'b1;
                    tbl_ctl.waddr = LAST_IDX;
                    tbl_wdata     = seed_scaled;
                end
            end
            S_WARM:
            begin
                tbl_ctl.we    = 1'b1;
                tbl_ctl.waddr = pos_reg;
                tbl_wdata     = cur_reg;
            end
            S_REF_WR:
            begin
                tbl_ctl.we = 1'b1;
            end
            S_DRAW_RD:
            begin
                tbl_ctl.raddr_a = rd_index_reg;
            end
            default:
            begin
                tbl_ctl.we = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        ridx_next         = ridx_reg;
        pass_next         = pass_reg;
        rd_index_next     = rd_index_reg;
        draw_next         = draw_reg;
        result_valid_next = result_valid_reg && !result_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.cmd == CMD_RESEED)
                    begin
                        draw_next  = 1'b0;
                        step_next  = IDX_W'(1);
                        pass_next  = 2'd0;
                        ridx_next  = '0;
                        state_next = S_WARM;
                    end
                    else if (rd_index_reg == LAST_IDX)
                    begin
                        // The read index wraps: renew the whole table first.
                        draw_next     = 1'b1;
                        rd_index_next = IDX_W'(1);
                        ridx_next     = '0;
                        state_next    = S_REF_RD;
                    end
                    else
                    begin
                        draw_next     = 1'b1;
                        rd_index_next = rd_index_reg + IDX_W'(1);
                        state_next    = S_DRAW_RD;
                    end
                end
            end
            S_WARM:
            begin
                step_next = step_reg + IDX_W'(1);
                if (step_reg == LAST_IDX)
                begin
                    state_next = S_REF_RD;
                end
            end
            S_REF_RD:
            begin
                state_next = S_REF_WR;
            end
            S_REF_WR:
            begin
                if (ridx_reg == LAST_IDX)
                begin
                    ridx_next = '0;
                    if (draw_reg)
                    begin
                        state_next = S_DRAW_RD;
                    end
                    else if (pass_reg == 2'd2)
                    begin
                        rd_index_next = '0;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        pass_next  = pass_reg + 2'd1;
                        state_next = S_REF_RD;
                    end
                end
                else
                begin
                    ridx_next  = ridx_reg + IDX_W'(1);
                    state_next = S_REF_RD;
                end
            end
            S_DRAW_RD:
            begin
                state_next = S_DRAW_LD;
            end
            S_DRAW_LD:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (scale_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // The output register takes the result once it is empty or being emptied.
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= '0;
            ridx_reg         <= '0;
            pass_reg         <= '0;
            rd_index_reg     <= '0;
            draw_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            seed_reg         <= SEED_BITS'(32'h8000_0000);
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            ridx_reg         <= ridx_next;
            pass_reg         <= pass_next;
            rd_index_reg     <= rd_index_next;
            draw_reg         <= draw_next;
            result_valid_reg <= result_valid_next;
            seed_reg         <= seed_next;
        end
    end

    // Working values carry no reset; the sequencer loads them before use.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lo_reg <= item.low_bound;
            hi_reg <= item.high_bound;
            if (item.cmd == CMD_RESEED)
            begin
                prev_reg <= seed_scaled;
                cur_reg  <= WARM_START;
                pos_reg  <= WARM_STEP;
            end
        end
        if (state_reg == S_WARM)
        begin
            // The value just written becomes the previous one.
            prev_reg <= cur_reg;
            cur_reg  <= sub_res;
            pos_reg  <= pos_wrap;
        end
        if (state_reg == S_OUT && (!result_valid_reg || result_ready))
        begin
            result_reg <= draw_reg ? scale_res : '0;
        end
    end

    slrg_table #(
        .FRAC_BITS (FRAC_BITS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (tbl_ctl),
        .wdata   (tbl_wdata),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    slrg_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scale_start),
        .frac       (rdata_a),
        .low_bound  (lo_reg),
        .high_bound (hi_reg),
        .done       (scale_done),
        .res        (scale_res)
    );

endmodule

`default_nettype wire

>>> dv/subtractive_lagged_random_generator_core_tb.sv
// Self-checking testbench for the subtractive lagged random generator core.
`timescale 1ns / 100ps

module subtractive_lagged_random_generator_core_tb;

    import slrg_pkg::*;

    // Clock, reset and run-length settings.
    localparam int unsigned CLK_HALF_NS   = 10;
    localparam int unsigned RESET_CYCLES  = 9;
    localparam int unsigned PHASES        = 8;
    localparam int unsigned PHASE_ITEMS   = 204;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 150;
    // A time limit well above the slowest legal run.
    localparam longint unsigned WATCHDOG_NS = 64'd60_000_000;

    // The seed register is the only register and sits at byte address zero.
    localparam logic [2:0]  SEED_ADDR     = 3'd0;
    localparam logic [31:0] SEED_AT_RESET = 32'h8000_0000;

    // Shape of the lagged generator: two lags, a scattered warm-up order and
    // the first warm-up value, which is 1e-9 in Q0.32 rounded to nearest.
    localparam int          TBL_LEN     = 55;
    localparam int          NEAR_LAG    = 24;
    localparam int          FAR_LAG     = 31;
    localparam int          SCATTER     = 21;
    localparam int          SCATTER_MOD = 54;
    localparam logic [31:0] WARM_FIRST  = 32'd4;

    localparam logic signed [BOUND_BITS-1:0] BOUND_MIN = {1'b1, {(BOUND_BITS - 1){1'b0}}};
    localparam logic signed [BOUND_BITS-1:0] BOUND_MAX = {1'b0, {(BOUND_BITS - 1){1'b1}}};

    // Tracks the generator's table and read position, predicts the result of
    // every accepted item and checks results against those predictions in order.
    class slrg_tracker;
        logic [31:0] frac_tbl [TBL_LEN];
        int unsigned draw_idx;
        logic [31:0] seed_frac;
        result_t     results_due [$];
        int unsigned mismatches;
        int unsigned checked;

        function new();
            foreach (frac_tbl[j])
                frac_tbl[j] = '0;
            draw_idx   = 0;
            seed_frac  = SEED_AT_RESET;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void note_failure(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $time, what);
        endfunction

        // One refresh pass: subtraction modulo one, walked in index order.
        function void refresh_pass();
            for (int j = 0; j < NEAR_LAG; j++)
                frac_tbl[j] = frac_tbl[j] - frac_tbl[j + FAR_LAG];
            for (int j = NEAR_LAG; j < TBL_LEN; j++)
                frac_tbl[j] = frac_tbl[j] - frac_tbl[j - NEAR_LAG];
        endfunction

        function void warm_up();
            logic [31:0] prev_val;
            logic [31:0] run_val;
            int unsigned pos;
            foreach (frac_tbl[j])
                frac_tbl[j] = '0;
            prev_val = seed_frac;
            frac_tbl[TBL_LEN - 1] = prev_val;
            run_val = WARM_FIRST;
            for (int j = 1; j < TBL_LEN; j++)
            begin
                pos = (SCATTER * j) % SCATTER_MOD;
                frac_tbl[pos] = run_val;
                run_val = prev_val - run_val;
                prev_val = frac_tbl[pos];
            end
            repeat (3)
                refresh_pass();
            draw_idx = 0;
        endfunction

        function void note_item(item_t it);
            result_t     due;
            longint      lo;
            longint      hi;
            longint      frac_w;
            longint      span;
            longint      scaled;
            longint      ival;
            logic [63:0] real_acc;
            due = '0;
            if (it.cmd == CMD_RESEED)
                warm_up();
            else
            begin
                draw_idx++;
                if (draw_idx >= TBL_LEN)
                begin
                    draw_idx = 1;
                    refresh_pass();
                end
                frac_w = frac_tbl[draw_idx];
                lo = it.low_bound;
                hi = it.high_bound;
                if (lo >= hi)
                    ival = lo;
                else
                begin
                    scaled = frac_w * (hi - lo + 1);
                    ival = lo + (scaled >> 32);
                    if (ival > hi)
                        ival = hi;
                end
                // The real value scales the magnitude of the span and then
                // applies its sign, so truncation goes toward zero.
                span = (hi >= lo) ? hi - lo : lo - hi;
                scaled = frac_w * span;
                real_acc = lo <<< 32;
                if (hi < lo)
                    real_acc = real_acc - scaled;
                else
                    real_acc = real_acc + scaled;
                due.fraction   = frac_tbl[draw_idx];
                due.int_value  = BOUND_BITS'(ival);
                due.real_value = real_acc[REAL_BITS-1:0];
            end
            results_due.push_back(due);
        endfunction

        function void check_result(result_t got);
            result_t due;
            checked++;
            if (results_due.size() == 0)
            begin
                note_failure($sformatf("result %0d arrived with none expected: %h", checked, got));
                return;
            end
            due = results_due.pop_front();
            if (got.fraction !== due.fraction)
                note_failure($sformatf("result %0d fraction: expected %h, got %h",
                                       checked, due.fraction, got.fraction));
            if (got.int_value !== due.int_value)
                note_failure($sformatf("result %0d int_value: expected %0d, got %0d",
                                       checked, due.int_value, got.int_value));
            if (got.real_value !== due.real_value)
                note_failure($sformatf("result %0d real_value: expected %h, got %h",
                                       checked, due.real_value, got.real_value));
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    item_t       item         = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result;

    // Random idling is switched per phase; the receiver serves long holds
    // whenever the stimulus raises the order count.
    logic        idle_on      = 1'b0;
    int unsigned hold_orders  = 0;

    slrg_tracker tracker = new();

    subtractive_lagged_random_generator_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // Offers one item and returns at the edge where it is taken. Valid stays
    // high afterwards so that a following item can go out back to back; any
    // caller that stops sending lowers it first.
    task automatic send_item(input item_t it);
        int unsigned gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        tracker.note_item(it);
    endtask

    // Stops offering items and waits until every predicted result is back.
    task automatic wait_drained();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.results_due.size() != 0);
    endtask

    // Writes the seed register, then reads it back in a second transfer that
    // follows straight on with psel held.
    task automatic program_seed(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SEED_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        tracker.seed_frac = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== value)
            tracker.note_failure($sformatf("seed readback: expected %h, got %h", value, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic signed [BOUND_BITS-1:0] corner_bound();
        case ($urandom_range(0, 3))
            0: return BOUND_MIN;
            1: return BOUND_MAX;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // Random bounds in several shapes: fully random, narrow ranges, equal
    // bounds, reversed bounds, corner values and power-of-two spans.
    function automatic item_t random_item(input logic cmd);
        item_t it;
        int    t;
        logic signed [BOUND_BITS-1:0] swap_val;
        it.cmd        = cmd;
        it.low_bound  = BOUND_BITS'($urandom());
        it.high_bound = BOUND_BITS'($urandom());
        case ($urandom_range(0, 9))
            4, 5:
            begin
                t = int'(it.low_bound) + int'($urandom_range(0, 20));
                if (t > int'(BOUND_MAX))
                    t = BOUND_MAX;
                it.high_bound = BOUND_BITS'(t);
            end
            6:
                it.high_bound = it.low_bound;
            7:
            begin
                if (it.low_bound < it.high_bound)
                begin
                    swap_val      = it.low_bound;
                    it.low_bound  = it.high_bound;
                    it.high_bound = swap_val;
                end
            end
            8:
            begin
                it.low_bound  = corner_bound();
                it.high_bound = corner_bound();
            end
            9:
            begin
                t = int'(it.low_bound) + (1 << $urandom_range(0, BOUND_BITS - 1));
                if (t > int'(BOUND_MAX))
                    t = BOUND_MAX;
                it.high_bound = BOUND_BITS'(t);
            end
            default:
                ;
        endcase
        return it;
    endfunction

    // Result side: checks every accepted result against the oldest prediction
    // and drives result_ready. Short random stalls come while idling is on;
    // a hold order from the stimulus drops ready for a long counted stretch so
    // that the block fills up and refuses further items.
    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned holds_served;
        stall_left   = 0;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
                tracker.check_result(result);
            if (hold_orders != holds_served)
            begin
                holds_served++;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 6);
            if (stall_left != 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Stimulus: a short directed opening, then phases of random items, each
    // phase under a fresh seed. Most items are draws; reseeds are sprinkled in
    // so that long runs of draws walk the table through several wraps.
    initial
    begin : stimulus
        item_t it;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Draws on the table left by reset: all entries are zero, so each
        // result is the lower bound alone, with extreme and reversed bounds.
        send_item(item_t'{CMD_DRAW, BOUND_MIN, BOUND_MAX});
        send_item(item_t'{CMD_DRAW, BOUND_MAX, BOUND_MIN});
        send_item(item_t'{CMD_DRAW, 24'sd0, 24'sd0});
        send_item(item_t'{CMD_DRAW, -24'sd1, 24'sd0});

        // The first warm-up uses the seed value held since reset, and its own
        // item returns all zeros whatever bounds it carries.
        send_item(item_t'{CMD_RESEED, BOUND_MAX, BOUND_MIN});
        send_item(item_t'{CMD_DRAW, BOUND_MIN, BOUND_MAX});
        send_item(item_t'{CMD_DRAW, BOUND_MAX, BOUND_MIN});
        send_item(item_t'{CMD_DRAW, BOUND_MIN, BOUND_MIN});
        send_item(item_t'{CMD_DRAW, BOUND_MAX, BOUND_MAX});
        send_item(item_t'{CMD_DRAW, 24'sd0, 24'sd1});
        send_item(item_t'{CMD_DRAW, -24'sd1, 24'sd1});
        send_item(item_t'{CMD_DRAW, 24'sd100, -24'sd100});
        send_item(item_t'{CMD_DRAW, BOUND_MIN, 24'sd0});
        send_item(item_t'{CMD_DRAW, 24'sd0, BOUND_MAX});

        // Warm-ups from the smallest and the largest seed.
        for (int k = 0; k < 2; k++)
        begin
            wait_drained();
            program_seed((k == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF);
            send_item(random_item(CMD_RESEED));
            repeat (3) send_item(random_item(CMD_DRAW));
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0: program_seed(SEED_AT_RESET);
                1: program_seed(32'h0000_0001);
                default: program_seed($urandom());
            endcase
            // One middle phase and the closing phase run with no idling.
            idle_on <= (ph != 3) && (ph != PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 2 && n == 40)
                    hold_orders <= hold_orders + 1;
                if (ph == 4 && n == 100)
                    wait_drained();
                // Each phase opens with a warm-up, except one that keeps
                // drawing from the table the previous phase left behind.
                if ((n == 0 && ph != 5) || $urandom_range(0, 39) == 0)
                    it = random_item(CMD_RESEED);
                else
                    it = random_item(CMD_DRAW);
                send_item(it);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.results_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #(WATCHDOG_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
